>>> src/lsc_pkg.sv
// ----------------------------------------------------------------------------
// lsc_pkg
// Shared types, constants and helpers of the landing setpoint controller.
// ----------------------------------------------------------------------------
package lsc_pkg;

   localparam int RAMP_TICKS_DEF = 250;
   localparam int GUIDE_WAIT     = 20;
   localparam int RAMP_START     = 50;
   localparam int DESC_WAIT      = 10;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   localparam logic signed [63:0] PI_Q30     = 64'sd3373259426;
   localparam logic signed [63:0] ONE_Q30    = 64'sd1073741824;
   localparam logic signed [63:0] KSCHED_Q16 = 64'sd1733679;
   localparam logic signed [63:0] KSCHED_LIM = 64'sh7FFF_FFFF_FFFF_FFFF / KSCHED_Q16;
   localparam logic signed [63:0] SCALE_Q16  = 64'sd65536;
   localparam logic signed [63:0] SCALE_Q32  = 64'sd4294967296;
   localparam logic signed [63:0] PID_DIV    = 64'sd625;

   localparam logic [3:0] MODE_MISSION  = 4'd1;
   localparam logic [3:0] MODE_GUIDANCE = 4'd2;
   localparam logic [3:0] MODE_DESCEND  = 4'd3;
   localparam logic [3:0] MODE_FINAL    = 4'd4;
   localparam logic [3:0] MODE_HOLD     = 4'b1110;

   typedef enum logic {
      ALU_MUL,
      ALU_DIV
   } alu_op_type;

   typedef struct packed {
      logic              start;
      alu_op_type        op;
      logic signed [63:0] a;
      logic signed [63:0] b;
   } alu_req_type;

   typedef struct packed {
      logic              done;
      logic signed [63:0] result;
   } alu_rsp_type;

   typedef struct packed {
      logic [23:0] prop_gain;
      logic [23:0] deriv_gain;
      logic [23:0] integ_gain;
      logic [15:0] mission_step;
      logic [22:0] takeoff_height;
      logic [15:0] pid_descent_step;
      logic [15:0] final_descent_step;
   } cfg_type;

   typedef enum logic [2:0] {
      CSR_PROP_GAIN,
      CSR_DERIV_GAIN,
      CSR_INTEG_GAIN,
      CSR_MISSION_STEP,
      CSR_TAKEOFF_HEIGHT,
      CSR_PID_DESCENT_STEP,
      CSR_FINAL_DESCENT_STEP
   } csr_index_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_DECODE,
      ST_THETA_MUL,
      ST_THETA_DIV,
      ST_X2_MUL,
      ST_X2_DIV,
      ST_H_MUL,
      ST_H_DIV1,
      ST_H_DIV2,
      ST_PROF,
      ST_POS_MUL,
      ST_POS_DIV,
      ST_PID_SETUP,
      ST_PID_M1,
      ST_PID_M2,
      ST_PID_M3,
      ST_PID_D625,
      ST_PID_DSHIFT,
      ST_PID_DRAD,
      ST_PID_KMUL,
      ST_PID_KDIV,
      ST_FINISH
   } seq_state_type;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      if (v > 64'sd2147483647) begin
         return 32'sh7FFF_FFFF;
      end
      if (v < -64'sd2147483648) begin
         return 32'sh8000_0000;
      end
      return signed'(v[31:0]);
   endfunction

   // divisors k*(k+1) of the cosine series, k = 9, 7, 5, 3, 1
   function automatic logic signed [63:0] horner_div(input logic [2:0] idx);
      logic signed [63:0] d;
      unique case (idx)
         3'd0: d = 64'sd90;
         3'd1: d = 64'sd56;
         3'd2: d = 64'sd30;
         3'd3: d = 64'sd12;
         default: d = 64'sd2;
      endcase
      return d;
   endfunction

endpackage

>>> src/lsc_serial_alu.sv
// ----------------------------------------------------------------------------
// lsc_serial_alu
// Bit-serial signed multiply and truncating divide, one bit per cycle.
// ----------------------------------------------------------------------------
module lsc_serial_alu (
   input  logic                 clock,
   input  logic                 reset,
   input  lsc_pkg::alu_req_type alu_req,
   output lsc_pkg::alu_rsp_type alu_rsp
);

   logic                busy_ff;
   logic                done_ff;
   logic                neg_ff;
   lsc_pkg::alu_op_type op_ff;
   logic [5:0]          cnt_ff;
   logic [63:0]         a_ff;
   logic [63:0]         b_ff;
   logic [63:0]         acc_ff;
   logic [63:0]         rem_ff;

   logic [63:0] a_mag;
   logic [63:0] b_mag;
   logic [64:0] rem_sh;
   logic [64:0] rem_dif;
   logic        fits;
   logic [63:0] mag;

   assign a_mag   = alu_req.a[63] ? 64'(-alu_req.a) : 64'(alu_req.a);
   assign b_mag   = alu_req.b[63] ? 64'(-alu_req.b) : 64'(alu_req.b);
   assign rem_sh  = {rem_ff, a_ff[63]};
   assign rem_dif = rem_sh - {1'b0, b_ff};
   assign fits    = !rem_dif[64];
   assign mag     = (op_ff == lsc_pkg::ALU_MUL) ? acc_ff : a_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (alu_req.start && !busy_ff) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 6'd1;
            if (cnt_ff == 6'd63) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (alu_req.start && !busy_ff) begin
         a_ff   <= a_mag;
         b_ff   <= b_mag;
         acc_ff <= '0;
         rem_ff <= '0;
         neg_ff <= alu_req.a[63] ^ alu_req.b[63];
         op_ff  <= alu_req.op;
      end else if (busy_ff) begin
         unique case (op_ff)
            lsc_pkg::ALU_MUL: begin
               if (b_ff[0]) begin
                  acc_ff <= acc_ff + a_ff;
               end
               a_ff <= {a_ff[62:0], 1'b0};
               b_ff <= {1'b0, b_ff[63:1]};
            end
            lsc_pkg::ALU_DIV: begin
               rem_ff <= fits ? rem_dif[63:0] : rem_sh[63:0];
               a_ff   <= {a_ff[62:0], fits};
            end
         endcase
      end
   end

   assign alu_rsp.done   = done_ff;
   assign alu_rsp.result = neg_ff ? signed'(64'(-mag)) : signed'(mag);

   assert property (@(posedge clock) disable iff (reset) alu_req.start |-> !busy_ff)
      else $error("alu started while busy");
   assert property (@(posedge clock) disable iff (reset) done_ff |-> !busy_ff)
      else $error("alu done while busy");
   assert property (@(posedge clock) disable iff (reset) done_ff |=> !done_ff)
      else $error("alu done longer than one cycle");

endmodule

>>> src/lsc_csr.sv
// ----------------------------------------------------------------------------
// lsc_csr
// Configuration registers behind the bus port.
// ----------------------------------------------------------------------------
module lsc_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [lsc_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [lsc_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [lsc_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready,
   output lsc_pkg::cfg_type                  cfg
);

   lsc_pkg::cfg_type        cfg_ff;
   lsc_pkg::csr_index_type  idx;
   logic                    wr_en;

   assign idx        = lsc_pkg::csr_index_type'(csr_paddr[4:2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.prop_gain          <= 24'd58720;
         cfg_ff.deriv_gain         <= 24'd6711;
         cfg_ff.integ_gain         <= 24'd8389;
         cfg_ff.mission_step       <= 16'd1966;
         cfg_ff.takeoff_height     <= 23'd327680;
         cfg_ff.pid_descent_step   <= 16'd262;
         cfg_ff.final_descent_step <= 16'd131;
      end else if (wr_en) begin
         case (idx)
            lsc_pkg::CSR_PROP_GAIN:          cfg_ff.prop_gain          <= csr_pwdata[23:0];
            lsc_pkg::CSR_DERIV_GAIN:         cfg_ff.deriv_gain         <= csr_pwdata[23:0];
            lsc_pkg::CSR_INTEG_GAIN:         cfg_ff.integ_gain         <= csr_pwdata[23:0];
            lsc_pkg::CSR_MISSION_STEP:       cfg_ff.mission_step       <= csr_pwdata[15:0];
            lsc_pkg::CSR_TAKEOFF_HEIGHT:     cfg_ff.takeoff_height     <= csr_pwdata[22:0];
            lsc_pkg::CSR_PID_DESCENT_STEP:   cfg_ff.pid_descent_step   <= csr_pwdata[15:0];
            lsc_pkg::CSR_FINAL_DESCENT_STEP: cfg_ff.final_descent_step <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (idx)
         lsc_pkg::CSR_PROP_GAIN:          csr_prdata = 32'(cfg_ff.prop_gain);
         lsc_pkg::CSR_DERIV_GAIN:         csr_prdata = 32'(cfg_ff.deriv_gain);
         lsc_pkg::CSR_INTEG_GAIN:         csr_prdata = 32'(cfg_ff.integ_gain);
         lsc_pkg::CSR_MISSION_STEP:       csr_prdata = 32'(cfg_ff.mission_step);
         lsc_pkg::CSR_TAKEOFF_HEIGHT:     csr_prdata = 32'(cfg_ff.takeoff_height);
         lsc_pkg::CSR_PID_DESCENT_STEP:   csr_prdata = 32'(cfg_ff.pid_descent_step);
         lsc_pkg::CSR_FINAL_DESCENT_STEP: csr_prdata = 32'(cfg_ff.final_descent_step);
         default:                         csr_prdata = '0;
      endcase
   end

endmodule

>>> src/landing_setpoint_controller_unit.sv
// ----------------------------------------------------------------------------
// landing_setpoint_controller_unit
// Setpoint sequencer for vision guided landing, Q16.16 fixed point.
// ----------------------------------------------------------------------------
// One request at a time is taken; the response for a tick waits in an output
// register while the next request is accepted. All multiplies and divides run
// through one bit-serial unit of 64 steps. Mission, final, hold, idle and
// waiting ticks use no operation; a guidance PID tick takes 10 operations, a
// descend PID tick up to 14 operations, and a ramp tick up to 23 operations.
// ----------------------------------------------------------------------------
module landing_setpoint_controller_unit #(
   parameter int RAMP_TICKS = lsc_pkg::RAMP_TICKS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [31:0]                    req_tdata,   // x_error, y_error, radius
   input  logic [3:0]                     req_tuser,   // mode
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [111:0]                   rsp_tdata,   // set_x, set_y, set_z, guidance_ticks
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [lsc_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [lsc_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [lsc_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);

   localparam int RampEnd = lsc_pkg::RAMP_START + RAMP_TICKS;
   localparam int GcW     = $clog2(RampEnd + 2);
   localparam int RampW   = $clog2(RAMP_TICKS + 1);

   lsc_pkg::cfg_type       cfg;
   lsc_pkg::alu_req_type   alu_req;
   lsc_pkg::alu_rsp_type   alu_rsp;
   lsc_pkg::seq_state_type state_ff, state_in;

   logic               issued_ff;
   logic               started_ff;
   logic [3:0]         mode_ff;
   logic signed [9:0]  ex_ff, ey_ff;
   logic [9:0]         rad_ff;
   logic signed [31:0] pos_ff [2];
   logic signed [31:0] pos_z_ff, step_x_ff, step_z_ff;
   logic signed [31:0] corr_ff [2];
   logic signed [31:0] integ_ff [2];
   logic signed [31:0] anchor_ff [2];
   logic signed [9:0]  prev_ff [2];
   logic signed [9:0]  lerr_ff [2];
   logic [9:0]         lrad_ff;
   logic [GcW-1:0]     gc_ff;
   logic [3:0]         dc_ff;
   logic signed [31:0] snap_x_ff, snap_y_ff, snap_z_ff;
   logic [RampW-1:0]   j_ff;
   logic               mirror_ff;
   logic signed [63:0] t_ff, h_ff, x2_ff, prof_ff, acc_ff;
   logic [2:0]         hidx_ff;
   logic               axis_ff;
   logic               sched_ff;
   logic signed [9:0]  e_ff;
   logic signed [10:0] ediff_ff;
   logic signed [31:0] inew_ff;
   logic               rsp_tvalid_ff;
   logic [111:0]       rsp_tdata_ff;

   logic               req_acc;
   logic               out_free;
   logic [GcW-1:0]     gc_nx;
   logic [3:0]         dc_nx;
   logic [GcW-1:0]     ramp_i;
   logic               in_ramp;
   logic               mirror_nx;
   logic [RampW-1:0]   j_nx;
   logic signed [31:0] pz_base;
   logic signed [63:0] c_val, diff_val, half_val, prof_nx, res;
   logic signed [9:0]  e_sel, eo_sel;
   logic signed [31:0] inew_sel;
   logic signed [16:0] e100;
   logic signed [23:0] ed5k;
   logic               last_axis_done;

   lsc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   lsc_serial_alu u_alu (
      .clock   (clock),
      .reset   (reset),
      .alu_req (alu_req),
      .alu_rsp (alu_rsp)
   );

   assign req_tready = (state_ff == lsc_pkg::ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign out_free   = !rsp_tvalid_ff || rsp_tready;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign res        = alu_rsp.result;

   assign gc_nx     = (gc_ff < GcW'(RampEnd + 1)) ? gc_ff + 1'b1 : gc_ff;
   assign dc_nx     = (dc_ff < 4'(lsc_pkg::DESC_WAIT)) ? dc_ff + 4'd1 : dc_ff;
   assign ramp_i    = gc_nx - GcW'(lsc_pkg::RAMP_START);
   assign in_ramp   = (gc_nx >= GcW'(lsc_pkg::RAMP_START)) && (gc_nx <= GcW'(RampEnd));
   assign mirror_nx = (int'(ramp_i) * 2) > RAMP_TICKS;
   assign j_nx      = mirror_nx ? RampW'(RAMP_TICKS - int'(ramp_i)) : RampW'(ramp_i);
   assign pz_base   = started_ff ? pos_z_ff : signed'(32'(cfg.takeoff_height));

   assign c_val    = h_ff[63] ? 64'sd0 : h_ff;
   assign diff_val = lsc_pkg::ONE_Q30 - c_val;
   assign half_val = ((diff_val >>> 1) + 64'sd8192) >>> 14;
   assign prof_nx  = mirror_ff ? (64'sd65536 - half_val) : half_val;

   assign e_sel    = axis_ff ? ey_ff : ex_ff;
   assign eo_sel   = prev_ff[axis_ff];
   assign inew_sel = lsc_pkg::sat32(64'(integ_ff[axis_ff]) + 64'(e_sel) + 64'(eo_sel));
   assign e100     = 17'(e_ff) * 17'sd100;
   assign ed5k     = 24'(ediff_ff) * 24'sd5000;
   assign last_axis_done = axis_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lsc_pkg::ST_IDLE: begin
            if (req_acc) state_in = lsc_pkg::ST_DECODE;
         end
         lsc_pkg::ST_DECODE: begin
            state_in = lsc_pkg::ST_FINISH;
            case (mode_ff)
               lsc_pkg::MODE_GUIDANCE: begin
                  if (in_ramp) state_in = lsc_pkg::ST_THETA_MUL;
                  else if (gc_nx > GcW'(RampEnd)) state_in = lsc_pkg::ST_PID_SETUP;
               end
               lsc_pkg::MODE_DESCEND: begin
                  if (dc_nx >= 4'(lsc_pkg::DESC_WAIT)) state_in = lsc_pkg::ST_PID_SETUP;
               end
               default: ;
            endcase
         end
         lsc_pkg::ST_THETA_MUL: if (alu_rsp.done) state_in = lsc_pkg::ST_THETA_DIV;
         lsc_pkg::ST_THETA_DIV: if (alu_rsp.done) state_in = lsc_pkg::ST_X2_MUL;
         lsc_pkg::ST_X2_MUL:    if (alu_rsp.done) state_in = lsc_pkg::ST_X2_DIV;
         lsc_pkg::ST_X2_DIV:    if (alu_rsp.done) state_in = lsc_pkg::ST_H_MUL;
         lsc_pkg::ST_H_MUL:     if (alu_rsp.done) state_in = lsc_pkg::ST_H_DIV1;
         lsc_pkg::ST_H_DIV1:    if (alu_rsp.done) state_in = lsc_pkg::ST_H_DIV2;
         lsc_pkg::ST_H_DIV2: begin
            if (alu_rsp.done) begin
               state_in = (hidx_ff == 3'd4) ? lsc_pkg::ST_PROF : lsc_pkg::ST_H_MUL;
            end
         end
         lsc_pkg::ST_PROF: begin
            state_in = (lrad_ff == '0) ? lsc_pkg::ST_FINISH : lsc_pkg::ST_POS_MUL;
         end
         lsc_pkg::ST_POS_MUL: if (alu_rsp.done) state_in = lsc_pkg::ST_POS_DIV;
         lsc_pkg::ST_POS_DIV: begin
            if (alu_rsp.done) begin
               state_in = last_axis_done ? lsc_pkg::ST_FINISH : lsc_pkg::ST_POS_MUL;
            end
         end
         lsc_pkg::ST_PID_SETUP: state_in = lsc_pkg::ST_PID_M1;
         lsc_pkg::ST_PID_M1: if (alu_rsp.done) state_in = lsc_pkg::ST_PID_M2;
         lsc_pkg::ST_PID_M2: if (alu_rsp.done) state_in = lsc_pkg::ST_PID_M3;
         lsc_pkg::ST_PID_M3: if (alu_rsp.done) state_in = lsc_pkg::ST_PID_D625;
         lsc_pkg::ST_PID_D625: begin
            if (alu_rsp.done) begin
               if (!sched_ff) state_in = lsc_pkg::ST_PID_DSHIFT;
               else if (lrad_ff != '0) state_in = lsc_pkg::ST_PID_DRAD;
               else state_in = last_axis_done ? lsc_pkg::ST_FINISH : lsc_pkg::ST_PID_SETUP;
            end
         end
         lsc_pkg::ST_PID_DSHIFT, lsc_pkg::ST_PID_KDIV: begin
            if (alu_rsp.done) begin
               state_in = last_axis_done ? lsc_pkg::ST_FINISH : lsc_pkg::ST_PID_SETUP;
            end
         end
         lsc_pkg::ST_PID_DRAD: begin
            if (alu_rsp.done) begin
               if (res > lsc_pkg::KSCHED_LIM || res < -lsc_pkg::KSCHED_LIM) begin
                  state_in = last_axis_done ? lsc_pkg::ST_FINISH : lsc_pkg::ST_PID_SETUP;
               end else begin
                  state_in = lsc_pkg::ST_PID_KMUL;
               end
            end
         end
         lsc_pkg::ST_PID_KMUL: if (alu_rsp.done) state_in = lsc_pkg::ST_PID_KDIV;
         lsc_pkg::ST_FINISH: begin
            if (out_free) state_in = lsc_pkg::ST_IDLE;
         end
         default: state_in = lsc_pkg::ST_IDLE;
      endcase
   end

   // alu operands
   always_comb begin
      alu_req       = '0;
      alu_req.op    = lsc_pkg::ALU_MUL;
      alu_req.start = !issued_ff;
      unique case (state_ff)
         lsc_pkg::ST_THETA_MUL: begin
            alu_req.a = lsc_pkg::PI_Q30;
            alu_req.b = signed'(64'(j_ff));
         end
         lsc_pkg::ST_THETA_DIV: begin
            alu_req.op = lsc_pkg::ALU_DIV;
            alu_req.a  = t_ff;
            alu_req.b  = 64'(RAMP_TICKS);
         end
         lsc_pkg::ST_X2_MUL: begin
            alu_req.a = t_ff;
            alu_req.b = t_ff;
         end
         lsc_pkg::ST_X2_DIV, lsc_pkg::ST_H_DIV1: begin
            alu_req.op = lsc_pkg::ALU_DIV;
            alu_req.a  = t_ff;
            alu_req.b  = lsc_pkg::ONE_Q30;
         end
         lsc_pkg::ST_H_MUL: begin
            alu_req.a = x2_ff;
            alu_req.b = h_ff;
         end
         lsc_pkg::ST_H_DIV2: begin
            alu_req.op = lsc_pkg::ALU_DIV;
            alu_req.a  = t_ff;
            alu_req.b  = lsc_pkg::horner_div(hidx_ff);
         end
         lsc_pkg::ST_POS_MUL: begin
            alu_req.a = 64'(lerr_ff[axis_ff]);
            alu_req.b = prof_ff;
         end
         lsc_pkg::ST_POS_DIV: begin
            alu_req.op = lsc_pkg::ALU_DIV;
            alu_req.a  = t_ff;
            alu_req.b  = signed'(64'({lrad_ff, 2'b00}));
         end
         lsc_pkg::ST_PID_M1: begin
            alu_req.a = signed'(64'(cfg.prop_gain));
            alu_req.b = 64'(e100);
         end
         lsc_pkg::ST_PID_M2: begin
            alu_req.a = signed'(64'(cfg.deriv_gain));
            alu_req.b = 64'(ed5k);
         end
         lsc_pkg::ST_PID_M3: begin
            alu_req.a = signed'(64'(cfg.integ_gain));
            alu_req.b = 64'(inew_ff);
         end
         lsc_pkg::ST_PID_D625: begin
            alu_req.op = lsc_pkg::ALU_DIV;
            alu_req.a  = acc_ff <<< 4;
            alu_req.b  = lsc_pkg::PID_DIV;
         end
         lsc_pkg::ST_PID_DSHIFT: begin
            alu_req.op = lsc_pkg::ALU_DIV;
            alu_req.a  = acc_ff;
            alu_req.b  = lsc_pkg::SCALE_Q16;
         end
         lsc_pkg::ST_PID_DRAD: begin
            alu_req.op = lsc_pkg::ALU_DIV;
            alu_req.a  = acc_ff;
            alu_req.b  = signed'(64'(lrad_ff));
         end
         lsc_pkg::ST_PID_KMUL: begin
            alu_req.a = t_ff;
            alu_req.b = lsc_pkg::KSCHED_Q16;
         end
         lsc_pkg::ST_PID_KDIV: begin
            alu_req.op = lsc_pkg::ALU_DIV;
            alu_req.a  = t_ff;
            alu_req.b  = lsc_pkg::SCALE_Q32;
         end
         default: alu_req.start = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= lsc_pkg::ST_IDLE;
         issued_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (alu_req.start) issued_ff <= 1'b1;
         else if (alu_rsp.done) issued_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff    <= 1'b0;
         pos_ff[0]     <= '0;
         pos_ff[1]     <= '0;
         pos_z_ff      <= '0;
         step_x_ff     <= '0;
         step_z_ff     <= '0;
         corr_ff[0]    <= '0;
         corr_ff[1]    <= '0;
         prev_ff[0]    <= 10'sd40;
         prev_ff[1]    <= 10'sd40;
         integ_ff[0]   <= '0;
         integ_ff[1]   <= '0;
         gc_ff         <= '0;
         dc_ff         <= '0;
         lerr_ff[0]    <= '0;
         lerr_ff[1]    <= '0;
         lrad_ff       <= '0;
         anchor_ff[0]  <= '0;
         anchor_ff[1]  <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         if (rsp_tvalid_ff && rsp_tready && state_ff != lsc_pkg::ST_FINISH) begin
            rsp_tvalid_ff <= 1'b0;
         end
         unique case (state_ff)
            lsc_pkg::ST_IDLE: begin
               if (req_acc) begin
                  started_ff <= 1'b1;
                  pos_ff[0] <= lsc_pkg::sat32(64'(pos_ff[0]) + 64'(step_x_ff)
                                              + 64'(corr_ff[0]));
                  pos_ff[1] <= lsc_pkg::sat32(64'(pos_ff[1]) + 64'(corr_ff[1]));
                  pos_z_ff  <= lsc_pkg::sat32(64'(pz_base) + 64'(step_z_ff));
               end
            end
            lsc_pkg::ST_DECODE: begin
               case (mode_ff)
                  lsc_pkg::MODE_MISSION: step_x_ff <= signed'(32'(cfg.mission_step));
                  lsc_pkg::MODE_GUIDANCE: begin
                     gc_ff <= gc_nx;
                     if (gc_nx < GcW'(lsc_pkg::GUIDE_WAIT)) begin
                        step_x_ff   <= '0;
                        prev_ff[0]  <= '0;
                        prev_ff[1]  <= '0;
                        integ_ff[0] <= '0;
                        integ_ff[1] <= '0;
                     end
                     if (gc_nx == GcW'(lsc_pkg::GUIDE_WAIT)) begin
                        lerr_ff[0]   <= ex_ff;
                        lerr_ff[1]   <= ey_ff;
                        lrad_ff      <= rad_ff;
                        anchor_ff[0] <= pos_ff[0];
                        anchor_ff[1] <= pos_ff[1];
                     end
                     if (!in_ramp && gc_nx > GcW'(RampEnd)) step_x_ff <= '0;
                  end
                  lsc_pkg::MODE_DESCEND: begin
                     dc_ff <= dc_nx;
                     if (dc_nx < 4'(lsc_pkg::DESC_WAIT)) begin
                        step_x_ff   <= '0;
                        step_z_ff   <= '0;
                        lrad_ff     <= rad_ff;
                        prev_ff[0]  <= '0;
                        prev_ff[1]  <= '0;
                        integ_ff[0] <= '0;
                        integ_ff[1] <= '0;
                     end else begin
                        step_z_ff <= -signed'(32'(cfg.pid_descent_step));
                     end
                  end
                  lsc_pkg::MODE_FINAL: begin
                     step_x_ff  <= '0;
                     corr_ff[0] <= '0;
                     corr_ff[1] <= '0;
                     step_z_ff  <= -signed'(32'(cfg.final_descent_step));
                  end
                  lsc_pkg::MODE_HOLD: begin
                     step_x_ff  <= '0;
                     corr_ff[0] <= '0;
                     corr_ff[1] <= '0;
                  end
                  default: ;
               endcase
            end
            lsc_pkg::ST_PROF: begin
               if (lrad_ff == '0) begin
                  pos_ff[0] <= anchor_ff[0];
                  pos_ff[1] <= anchor_ff[1];
               end
            end
            lsc_pkg::ST_POS_DIV: begin
               if (alu_rsp.done) begin
                  pos_ff[axis_ff] <= lsc_pkg::sat32(64'(anchor_ff[axis_ff]) + res);
               end
            end
            lsc_pkg::ST_PID_SETUP: begin
               integ_ff[axis_ff] <= inew_sel;
               prev_ff[axis_ff]  <= e_sel;
            end
            lsc_pkg::ST_PID_D625: begin
               if (alu_rsp.done && sched_ff && lrad_ff == '0) corr_ff[axis_ff] <= '0;
            end
            lsc_pkg::ST_PID_DSHIFT, lsc_pkg::ST_PID_KDIV: begin
               if (alu_rsp.done) corr_ff[axis_ff] <= lsc_pkg::sat32(res);
            end
            lsc_pkg::ST_PID_DRAD: begin
               if (alu_rsp.done) begin
                  if (res > lsc_pkg::KSCHED_LIM) corr_ff[axis_ff] <= 32'sh7FFF_FFFF;
                  else if (res < -lsc_pkg::KSCHED_LIM) corr_ff[axis_ff] <= 32'sh8000_0000;
               end
            end
            lsc_pkg::ST_FINISH: begin
               if (out_free) rsp_tvalid_ff <= 1'b1;
            end
            default: ;
         endcase
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      unique case (state_ff)
         lsc_pkg::ST_IDLE: begin
            if (req_acc) begin
               mode_ff   <= req_tuser;
               ex_ff     <= signed'(req_tdata[9:0]);
               ey_ff     <= signed'(req_tdata[19:10]);
               rad_ff    <= req_tdata[29:20];
               snap_x_ff <= lsc_pkg::sat32(64'(pos_ff[0]) + 64'(step_x_ff)
                                           + 64'(corr_ff[0]));
               snap_y_ff <= lsc_pkg::sat32(64'(pos_ff[1]) + 64'(corr_ff[1]));
               snap_z_ff <= lsc_pkg::sat32(64'(pz_base) + 64'(step_z_ff));
            end
         end
         lsc_pkg::ST_DECODE: begin
            j_ff      <= j_nx;
            mirror_ff <= mirror_nx;
            axis_ff   <= 1'b0;
            hidx_ff   <= '0;
            sched_ff  <= (mode_ff == lsc_pkg::MODE_DESCEND);
         end
         lsc_pkg::ST_THETA_MUL, lsc_pkg::ST_THETA_DIV, lsc_pkg::ST_X2_MUL,
         lsc_pkg::ST_H_MUL, lsc_pkg::ST_H_DIV1, lsc_pkg::ST_POS_MUL,
         lsc_pkg::ST_PID_KMUL: begin
            if (alu_rsp.done) t_ff <= res;
         end
         lsc_pkg::ST_X2_DIV: begin
            if (alu_rsp.done) begin
               x2_ff   <= res;
               h_ff    <= lsc_pkg::ONE_Q30;
               hidx_ff <= '0;
            end
         end
         lsc_pkg::ST_H_DIV2: begin
            if (alu_rsp.done) begin
               h_ff    <= lsc_pkg::ONE_Q30 - res;
               hidx_ff <= hidx_ff + 3'd1;
            end
         end
         lsc_pkg::ST_PROF: begin
            prof_ff <= prof_nx;
            axis_ff <= 1'b0;
         end
         lsc_pkg::ST_POS_DIV, lsc_pkg::ST_PID_DSHIFT, lsc_pkg::ST_PID_KDIV: begin
            if (alu_rsp.done) axis_ff <= 1'b1;
         end
         lsc_pkg::ST_PID_SETUP: begin
            e_ff     <= e_sel;
            ediff_ff <= 11'(e_sel) - 11'(eo_sel);
            inew_ff  <= inew_sel;
         end
         lsc_pkg::ST_PID_M1: begin
            if (alu_rsp.done) acc_ff <= res;
         end
         lsc_pkg::ST_PID_M2, lsc_pkg::ST_PID_M3: begin
            if (alu_rsp.done) acc_ff <= acc_ff + res;
         end
         lsc_pkg::ST_PID_D625: begin
            if (alu_rsp.done) begin
               acc_ff <= res;
               if (sched_ff && lrad_ff == '0) axis_ff <= 1'b1;
            end
         end
         lsc_pkg::ST_PID_DRAD: begin
            if (alu_rsp.done) begin
               t_ff <= res;
               if (res > lsc_pkg::KSCHED_LIM || res < -lsc_pkg::KSCHED_LIM) axis_ff <= 1'b1;
            end
         end
         lsc_pkg::ST_FINISH: begin
            if (out_free) begin
               rsp_tdata_ff <= {7'b0, 9'(gc_ff), snap_z_ff, snap_y_ff, snap_x_ff};
            end
         end
         default: ;
      endcase
   end

   assert property (@(posedge clock) disable iff (reset) alu_rsp.done |-> issued_ff)
      else $error("alu result without an issued operation");
   assert property (@(posedge clock) disable iff (reset)
                    (state_ff == lsc_pkg::ST_IDLE) |-> !issued_ff)
      else $error("operation pending while idle");
   assert property (@(posedge clock) disable iff (reset) gc_ff <= GcW'(RampEnd + 1))
      else $error("guidance counter beyond saturation");
   assert property (@(posedge clock) disable iff (reset)
                    dc_ff <= 4'(lsc_pkg::DESC_WAIT))
      else $error("descend counter beyond saturation");

endmodule

>>> tb/landing_setpoint_controller_unit_tb.sv
// ----------------------------------------------------------------------------
// landing_setpoint_controller_unit_tb
// Self-checking bench for the landing setpoint controller. A queue-fed driver
// sends control ticks and a clocked monitor checks each setpoint result
// against a fixed-point model of the controller kept inside the bench. The
// run goes through several register settings and flow-control phases.
// ----------------------------------------------------------------------------
module landing_setpoint_controller_unit_tb;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int      RAMP_LEN     = 250;
   localparam int      UNMAPPED_IDX = 7;
   localparam longint  Q30_ONE      = 64'sd1073741824;
   localparam longint  Q30_PI       = 64'sd3373259426;
   localparam longint  DESC_GAIN    = 64'sd1733679;
   localparam longint  Q32_SCALE    = 64'sd4294967296;
   localparam longint  I32_MAX      = 64'sd2147483647;
   localparam longint  I32_MIN      = -64'sd2147483648;

   typedef struct {
      logic [3:0]        mode;
      logic signed [9:0] ex;
      logic signed [9:0] ey;
      logic [9:0]        radius;
      bit                drain;
   } tick_type;

   typedef struct {
      logic [31:0] sx;
      logic [31:0] sy;
      logic [31:0] sz;
      logic [8:0]  ticks;
   } setpoint_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [31:0]  req_tdata = '0;   // x_error, y_error, radius
   logic [3:0]   req_tuser = '0;   // mode
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [111:0] rsp_tdata;       // set_x, set_y, set_z, guidance_ticks
   logic         csr_psel = 1'b0;
   logic         csr_penable = 1'b0;
   logic         csr_pwrite = 1'b0;
   logic [lsc_pkg::CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [lsc_pkg::CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [lsc_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic         csr_pready;

   landing_setpoint_controller_unit #(.RAMP_TICKS(RAMP_LEN)) u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata), .csr_pready(csr_pready)
   );

   tick_type     tick_q[$];
   setpoint_type setpoint_q[$];
   tick_type     cur_tick;
   int           send_idle_pct = 0;
   int           recv_stall_pct = 0;
   int           mismatches = 0;
   bit           long_hold_arm = 0;
   bit           long_hold_done = 0;
   int           hold_left = 0;

   // controller model
   longint kp, kd, ki, m_step, to_height, pd_step, fd_step;
   int     pos_x, pos_y, pos_z, step_x, step_z, corr_x, corr_y;
   int     prev_x, prev_y, integ_x, integ_y;
   int     guide_cnt, desc_cnt, lat_ex, lat_ey, anchor_x, anchor_y;
   longint lat_rad;
   bit     started;

   function automatic int clamp32(longint v);
      if (v > I32_MAX) return int'(I32_MAX);
      if (v < I32_MIN) return int'(I32_MIN);
      return int'(v);
   endfunction

   function automatic longint raised_cosine(longint i);
      longint j, theta, x2, h, c, half;
      bit     mirror;
      mirror = (2 * i > RAMP_LEN);
      j = mirror ? (RAMP_LEN - i) : i;
      theta = (Q30_PI * j) / RAMP_LEN;
      x2 = (theta * theta) / Q30_ONE;
      h = Q30_ONE;
      for (longint k = 9; k >= 1; k -= 2) begin
         h = Q30_ONE - ((x2 * h) / Q30_ONE) / (k * (k + 1));
      end
      c = (h < 0) ? 0 : h;
      half = ((Q30_ONE - c) / 2 + 8192) / 16384;
      return mirror ? (65536 - half) : half;
   endfunction

   function automatic int ramp_target(int anchor, int err, longint prof);
      longint d;
      d = 0;
      if (lat_rad != 0) d = (longint'(err) * prof) / (4 * lat_rad);
      return clamp32(longint'(anchor) + d);
   endfunction

   function automatic int pid_corr(longint e, ref int prev, ref int integ, input bit sched);
      longint eo, inew, n, p, q, lim;
      eo = prev;
      inew = clamp32(longint'(integ) + e + eo);
      integ = int'(inew);
      prev = int'(e);
      n = 100 * kp * e + 5000 * kd * (e - eo) + ki * inew;
      p = (n * 16) / 625;
      if (!sched) return clamp32(p / 65536);
      if (lat_rad == 0) return 0;
      q = p / lat_rad;
      lim = 64'sh7FFF_FFFF_FFFF_FFFF / DESC_GAIN;
      if (q > lim) return int'(I32_MAX);
      if (q < -lim) return int'(I32_MIN);
      return clamp32((q * DESC_GAIN) / Q32_SCALE);
   endfunction

   function automatic void model_reset();
      kp = 58720; kd = 6711; ki = 8389; m_step = 1966; to_height = 327680;
      pd_step = 262; fd_step = 131;
      pos_x = 0; pos_y = 0; pos_z = 0; step_x = 0; step_z = 0;
      corr_x = 0; corr_y = 0; prev_x = 40; prev_y = 40; integ_x = 0; integ_y = 0;
      guide_cnt = 0; desc_cnt = 0; lat_ex = 0; lat_ey = 0; lat_rad = 0;
      anchor_x = 0; anchor_y = 0; started = 0;
   endfunction

   function automatic void model_config(int idx, logic [31:0] v);
      case (idx)
         lsc_pkg::CSR_PROP_GAIN:          kp = v[23:0];
         lsc_pkg::CSR_DERIV_GAIN:         kd = v[23:0];
         lsc_pkg::CSR_INTEG_GAIN:         ki = v[23:0];
         lsc_pkg::CSR_MISSION_STEP:       m_step = v[15:0];
         lsc_pkg::CSR_TAKEOFF_HEIGHT:     to_height = v[22:0];
         lsc_pkg::CSR_PID_DESCENT_STEP:   pd_step = v[15:0];
         lsc_pkg::CSR_FINAL_DESCENT_STEP: fd_step = v[15:0];
         default: ;
      endcase
   endfunction

   function automatic void predict_tick(tick_type t);
      setpoint_type s;
      longint       ex, ey, prof;
      ex = t.ex;
      ey = t.ey;
      if (!started) begin
         pos_z = int'(to_height);
         guide_cnt = 0;
         desc_cnt = 0;
      end
      pos_x = clamp32(longint'(pos_x) + step_x + corr_x);
      pos_y = clamp32(longint'(pos_y) + corr_y);
      pos_z = clamp32(longint'(pos_z) + step_z);
      started = 1;
      s.sx = pos_x;
      s.sy = pos_y;
      s.sz = pos_z;
      if (t.mode == lsc_pkg::MODE_MISSION) begin
         step_x = int'(m_step);
      end else if (t.mode == lsc_pkg::MODE_GUIDANCE) begin
         if (guide_cnt < lsc_pkg::RAMP_START + RAMP_LEN + 1) guide_cnt++;
         if (guide_cnt < lsc_pkg::GUIDE_WAIT) begin
            step_x = 0; prev_x = 0; prev_y = 0; integ_x = 0; integ_y = 0;
         end
         if (guide_cnt == lsc_pkg::GUIDE_WAIT) begin
            lat_ex = int'(ex); lat_ey = int'(ey); lat_rad = t.radius;
            anchor_x = pos_x; anchor_y = pos_y;
         end
         if (guide_cnt >= lsc_pkg::RAMP_START
             && guide_cnt <= lsc_pkg::RAMP_START + RAMP_LEN) begin
            prof = raised_cosine(guide_cnt - lsc_pkg::RAMP_START);
            pos_x = ramp_target(anchor_x, lat_ex, prof);
            pos_y = ramp_target(anchor_y, lat_ey, prof);
         end else if (guide_cnt > lsc_pkg::RAMP_START + RAMP_LEN) begin
            step_x = 0;
            corr_x = pid_corr(ex, prev_x, integ_x, 0);
            corr_y = pid_corr(ey, prev_y, integ_y, 0);
         end
      end else if (t.mode == lsc_pkg::MODE_DESCEND) begin
         if (desc_cnt < lsc_pkg::DESC_WAIT) desc_cnt++;
         if (desc_cnt < lsc_pkg::DESC_WAIT) begin
            step_x = 0; step_z = 0; lat_rad = t.radius;
            prev_x = 0; prev_y = 0; integ_x = 0; integ_y = 0;
         end else begin
            corr_x = pid_corr(ex, prev_x, integ_x, 1);
            corr_y = pid_corr(ey, prev_y, integ_y, 1);
            step_z = -int'(pd_step);
         end
      end else if (t.mode == lsc_pkg::MODE_FINAL) begin
         step_x = 0; corr_x = 0; corr_y = 0; step_z = -int'(fd_step);
      end else if (t.mode == lsc_pkg::MODE_HOLD) begin
         step_x = 0; corr_x = 0; corr_y = 0;
      end
      s.ticks = guide_cnt[8:0];
      setpoint_q.push_back(s);
   endfunction

   initial begin
      forever #10 clock = ~clock;
   end

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) predict_tick(cur_tick);
         if (!req_tvalid || req_tready) begin
            if (tick_q.size() != 0 && !(tick_q[0].drain && setpoint_q.size() != 0)
                && $urandom_range(99) >= send_idle_pct) begin
               cur_tick = tick_q.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= {2'b00, cur_tick.radius, cur_tick.ey, cur_tick.ex};
               req_tuser <= cur_tick.mode;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // response ready with random stalls and one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (long_hold_arm && !long_hold_done) begin
            hold_left = 3000;
            long_hold_done = 1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // response checker
   always @(posedge clock) begin
      setpoint_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (setpoint_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %h", rsp_tdata);
         end else begin
            e = setpoint_q.pop_front();
            if (rsp_tdata[31:0] !== e.sx || rsp_tdata[63:32] !== e.sy
                || rsp_tdata[95:64] !== e.sz || rsp_tdata[104:96] !== e.ticks) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp x=%h y=%h z=%h t=%0d got x=%h y=%h z=%h t=%0d",
                           e.sx, e.sy, e.sz, e.ticks, rsp_tdata[31:0], rsp_tdata[63:32],
                           rsp_tdata[95:64], rsp_tdata[104:96]);
            end
         end
      end
   end

   task automatic csr_write(int idx, logic [31:0] v);
      @(posedge clock);
      csr_psel <= 1'b1; csr_penable <= 1'b0; csr_pwrite <= 1'b1;
      csr_paddr <= lsc_pkg::CSR_ADDR_W'(4 * idx); csr_pwdata <= v;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      model_config(idx, v);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
   endtask

   task automatic settle();
      @(posedge clock);
      while (tick_q.size() != 0 || setpoint_q.size() != 0 || req_tvalid) @(posedge clock);
      repeat (1600) @(posedge clock);
   endtask

   function automatic void add_tick(logic [3:0] m, logic signed [9:0] ex,
                                    logic signed [9:0] ey, logic [9:0] r, bit drain);
      tick_type t;
      t.mode = m; t.ex = ex; t.ey = ey; t.radius = r; t.drain = drain;
      tick_q.push_back(t);
   endfunction

   function automatic logic [3:0] pick_mode();
      int          r;
      logic [3:0]  m;
      r = $urandom_range(99);
      if (r < 35) return lsc_pkg::MODE_GUIDANCE;
      if (r < 70) return lsc_pkg::MODE_DESCEND;
      if (r < 80) return lsc_pkg::MODE_MISSION;
      if (r < 88) return lsc_pkg::MODE_FINAL;
      if (r < 95) return lsc_pkg::MODE_HOLD;
      do m = 4'($urandom);
      while (m == lsc_pkg::MODE_MISSION || m == lsc_pkg::MODE_GUIDANCE
             || m == lsc_pkg::MODE_DESCEND || m == lsc_pkg::MODE_FINAL
             || m == lsc_pkg::MODE_HOLD);
      return m;
   endfunction

   function automatic logic signed [9:0] pick_err();
      if ($urandom_range(3) == 0) return 10'($signed($urandom_range(80)) - 40);
      return 10'($urandom);
   endfunction

   function automatic void add_random(int n);
      for (int i = 0; i < n; i++)
         add_tick(pick_mode(), pick_err(), pick_err(), 10'($urandom),
                  $urandom_range(99) == 0);
   endfunction

   initial begin
      model_reset();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: every mode code with field extremes, then descend waits
      // ending on a zero radius and a first descend pid tick
      @(negedge clock);
      for (int m = 0; m < 16; m++)
         add_tick(4'(m), (m % 2) ? 10'sd511 : -10'sd512, (m % 2) ? -10'sd512 : 10'sd511,
                  (m % 3 == 0) ? 10'd1023 : 10'd0, 0);
      for (int k = 0; k < 8; k++)
         add_tick(lsc_pkg::MODE_DESCEND, 10'sd511, -10'sd512,
                  (k == 7) ? 10'd0 : 10'd1023, 0);
      add_tick(lsc_pkg::MODE_DESCEND, -10'sd512, 10'sd511, 10'd1023, 0);
      settle();

      // moderate gains, sender idling, guidance flight through the ramp
      csr_write(lsc_pkg::CSR_PROP_GAIN, 32'd120000);
      csr_write(lsc_pkg::CSR_DERIV_GAIN, 32'd9000);
      csr_write(lsc_pkg::CSR_INTEG_GAIN, 32'd20000);
      csr_write(lsc_pkg::CSR_MISSION_STEP, 32'd3000);
      csr_write(lsc_pkg::CSR_PID_DESCENT_STEP, 32'd500);
      csr_write(lsc_pkg::CSR_FINAL_DESCENT_STEP, 32'd250);
      send_idle_pct = 88;
      recv_stall_pct = 0;
      @(negedge clock);
      for (int i = 0; i < 12; i++)
         add_tick(lsc_pkg::MODE_MISSION, pick_err(), pick_err(), 10'd5, 0);
      long_hold_arm = 1;
      for (int i = 0; i < 305; i++)
         add_tick(lsc_pkg::MODE_GUIDANCE, pick_err(), pick_err(),
                  10'($urandom_range(1023, 1)), i == 0);
      add_random(200);
      settle();

      // top extremes with over-width writes, receiver stalling
      csr_write(lsc_pkg::CSR_PROP_GAIN, 32'hFFFF_FFFF);
      csr_write(lsc_pkg::CSR_DERIV_GAIN, 32'h00FF_FFFF);
      csr_write(lsc_pkg::CSR_INTEG_GAIN, 32'h00FF_FFFF);
      csr_write(lsc_pkg::CSR_MISSION_STEP, 32'hFFFF_FFFF);
      csr_write(lsc_pkg::CSR_TAKEOFF_HEIGHT, 32'd6553600);
      csr_write(lsc_pkg::CSR_PID_DESCENT_STEP, 32'h0000_FFFF);
      csr_write(lsc_pkg::CSR_FINAL_DESCENT_STEP, 32'h0001_FFFF);
      send_idle_pct = 0;
      recv_stall_pct = 88;
      @(negedge clock);
      add_random(550);
      settle();

      // zero settings but for the integral gain, both sides idling
      csr_write(lsc_pkg::CSR_PROP_GAIN, 32'd0);
      csr_write(lsc_pkg::CSR_DERIV_GAIN, 32'd0);
      csr_write(lsc_pkg::CSR_INTEG_GAIN, 32'd0);
      csr_write(lsc_pkg::CSR_MISSION_STEP, 32'd0);
      csr_write(lsc_pkg::CSR_TAKEOFF_HEIGHT, 32'd0);
      csr_write(lsc_pkg::CSR_PID_DESCENT_STEP, 32'd0);
      csr_write(lsc_pkg::CSR_FINAL_DESCENT_STEP, 32'd0);
      csr_write(UNMAPPED_IDX, 32'hFFFF_FFFF);
      csr_write(lsc_pkg::CSR_INTEG_GAIN, 32'd400000);
      send_idle_pct = 31;
      recv_stall_pct = 31;
      @(negedge clock);
      add_random(550);
      settle();

      if (mismatches == 0 && setpoint_q.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin
      #(64'd12_000_000 * 20);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

>>> landing_setpoint_controller_unit.f
src/lsc_pkg.sv
src/lsc_serial_alu.sv
src/lsc_csr.sv
src/landing_setpoint_controller_unit.sv
tb/landing_setpoint_controller_unit_tb.sv
